[rtl/ccnb_tok_pkg.sv]
// Shared types and constants for the CCNb element tokenizer.
// Used by ccnb_tok_parse, ccnb_tok_outbuf and ccnb_element_tokenizer_unit.
// Depends on nothing else.
package ccnb_tok_pkg;

   // Field widths of one token.
   localparam int TOL_W   = 25;
   localparam int DATA_W  = 8;
   localparam int DEPTH_W = 5;
   // Width used when comparing a depth against the effective limit.
   localparam int LIM_W   = 7;

   // Default header length limit and the hard ceiling on nesting depth.
   localparam int HDR_BYTES_DEF = 4;
   localparam int MAX_DEPTH     = 16;

   // Reset value of the depth limit register.
   localparam logic [DEPTH_W-1:0] DEPTH_LIMIT_RST = 5'd16;

   // Register addresses on the configuration port (word index).
   localparam logic REG_DEPTH_LIMIT = 1'b0;

   // Header type codes carried in the low three bits of the closing byte.
   localparam logic [2:0] HT_DTAG  = 3'd2;
   localparam logic [2:0] HT_DATTR = 3'd4;
   localparam logic [2:0] HT_BLOB  = 3'd5;
   localparam logic [2:0] HT_UDATA = 3'd6;

   typedef enum logic [1:0] {
      MODE_HEADER  = 2'd0,
      MODE_PAYLOAD = 2'd1,
      MODE_ERROR   = 2'd2,
      MODE_DONE    = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      KIND_OPEN_TAG  = 3'd0,
      KIND_OPEN_ATTR = 3'd1,
      KIND_BLOB      = 3'd2,
      KIND_TEXT      = 3'd3,
      KIND_PAYLOAD   = 3'd4,
      KIND_CLOSE     = 3'd5,
      KIND_END       = 3'd6,
      KIND_ERROR     = 3'd7
   } kind_type;

   // Parser state apart from the header byte count, whose width follows
   // the header length parameter.
   typedef struct packed {
      mode_type           mode;
      logic [TOL_W-1:0]   accum;
      logic [TOL_W-1:0]   left;
      logic [DEPTH_W-1:0] depth;
   } state_type;

   typedef struct packed {
      kind_type           kind;
      logic [TOL_W-1:0]   tol;
      logic [DATA_W-1:0]  data;
      logic [DEPTH_W-1:0] depth;
      logic               last;
   } token_type;

endpackage

[rtl/ccnb_tok_parse.sv]
// Single-pass parse step: next parser state and up to two tokens for one byte.
// Purely combinational; depends on ccnb_tok_pkg.
// The parser state registers live in the top level.
module ccnb_tok_parse #(
   parameter int HDR_BYTES = ccnb_tok_pkg::HDR_BYTES_DEF,
   localparam int HCW = (HDR_BYTES > 1) ? $clog2(HDR_BYTES) : 1
) (
   input  logic [7:0]                           in_byte,
   input  logic                                 sop,
   input  logic                                 last,
   input  ccnb_tok_pkg::state_type              st,
   input  logic [HCW-1:0]                       hcount,
   input  logic [ccnb_tok_pkg::DEPTH_W-1:0]     depth_limit,
   output ccnb_tok_pkg::state_type              st_in,
   output logic [HCW-1:0]                       hcount_in,
   output ccnb_tok_pkg::token_type              tok0,
   output ccnb_tok_pkg::token_type              tok1,
   output logic [1:0]                           ntok
);

   ccnb_tok_pkg::state_type                    cur;
   logic [HCW-1:0]                             hc;
   logic [HCW:0]                               hc_plus;
   logic [ccnb_tok_pkg::LIM_W-1:0]             lim_eff;
   logic [ccnb_tok_pkg::LIM_W-1:0]             depth_plus;
   logic [ccnb_tok_pkg::TOL_W-1:0]             num;
   logic [ccnb_tok_pkg::TOL_W-1:0]             left_dec;
   logic [2:0]                                 typ;
   logic                                       active;
   logic                                       emit;
   logic                                       tail_err;
   ccnb_tok_pkg::kind_type                     kind;
   logic [ccnb_tok_pkg::TOL_W-1:0]             tol;
   logic [ccnb_tok_pkg::DATA_W-1:0]            dbyte;
   ccnb_tok_pkg::token_type                    err_tok;

   // Effective limit is the smaller of the register and the hard ceiling.
   always_comb begin
      if ({2'b00, depth_limit} < ccnb_tok_pkg::LIM_W'(ccnb_tok_pkg::MAX_DEPTH)) begin
         lim_eff = {2'b00, depth_limit};
      end else begin
         lim_eff = ccnb_tok_pkg::LIM_W'(ccnb_tok_pkg::MAX_DEPTH);
      end
   end

   always_comb begin
      // Start of packet clears the state before this byte is looked at.
      cur = st;
      hc  = hcount;
      if (sop) begin
         cur.mode  = ccnb_tok_pkg::MODE_HEADER;
         cur.accum = '0;
         cur.left  = '0;
         cur.depth = '0;
         hc        = '0;
      end

      hc_plus    = {1'b0, hc} + (HCW+1)'(1);
      depth_plus = {2'b00, cur.depth} + ccnb_tok_pkg::LIM_W'(1);
      num        = {cur.accum[ccnb_tok_pkg::TOL_W-5:0], in_byte[6:3]};
      typ        = in_byte[2:0];
      left_dec   = cur.left - ccnb_tok_pkg::TOL_W'(1);

      st_in     = cur;
      hcount_in = hc;
      active    = 1'b1;
      emit      = 1'b0;
      kind      = ccnb_tok_pkg::KIND_ERROR;
      tol       = '0;
      dbyte     = '0;

      case (cur.mode)
         ccnb_tok_pkg::MODE_HEADER: begin
            if (hc == '0 && in_byte == 8'h00) begin
               // A zero in first header position closes an element or ends
               // the packet at the outermost level.
               emit = 1'b1;
               if (cur.depth == '0) begin
                  st_in.mode = ccnb_tok_pkg::MODE_DONE;
                  kind       = ccnb_tok_pkg::KIND_END;
               end else begin
                  st_in.depth = cur.depth - ccnb_tok_pkg::DEPTH_W'(1);
                  kind        = ccnb_tok_pkg::KIND_CLOSE;
               end
            end else if (!in_byte[7]) begin
               st_in.accum = {cur.accum[ccnb_tok_pkg::TOL_W-8:0], in_byte[6:0]};
               hcount_in   = hc_plus[HCW-1:0];
               if (hc_plus >= (HCW+1)'(HDR_BYTES)) begin
                  emit       = 1'b1;
                  st_in.mode = ccnb_tok_pkg::MODE_ERROR;
               end
            end else begin
               emit        = 1'b1;
               st_in.accum = '0;
               hcount_in   = '0;
               case (typ) inside
                  ccnb_tok_pkg::HT_DTAG, ccnb_tok_pkg::HT_DATTR: begin
                     if (depth_plus > lim_eff) begin
                        st_in.mode = ccnb_tok_pkg::MODE_ERROR;
                     end else begin
                        st_in.depth = depth_plus[ccnb_tok_pkg::DEPTH_W-1:0];
                        kind = (typ == ccnb_tok_pkg::HT_DTAG) ? ccnb_tok_pkg::KIND_OPEN_TAG
                                                              : ccnb_tok_pkg::KIND_OPEN_ATTR;
                        tol  = num;
                     end
                  end
                  ccnb_tok_pkg::HT_BLOB, ccnb_tok_pkg::HT_UDATA: begin
                     kind = (typ == ccnb_tok_pkg::HT_BLOB) ? ccnb_tok_pkg::KIND_BLOB
                                                           : ccnb_tok_pkg::KIND_TEXT;
                     tol  = num;
                     // An empty payload stays in header mode.
                     if (num != '0) begin
                        st_in.left = num;
                        st_in.mode = ccnb_tok_pkg::MODE_PAYLOAD;
                     end
                  end
                  default: begin
                     st_in.mode = ccnb_tok_pkg::MODE_ERROR;
                  end
               endcase
            end
         end
         ccnb_tok_pkg::MODE_PAYLOAD: begin
            emit       = 1'b1;
            kind       = ccnb_tok_pkg::KIND_PAYLOAD;
            dbyte      = in_byte;
            st_in.left = left_dec;
            if (left_dec == '0) begin
               st_in.mode = ccnb_tok_pkg::MODE_HEADER;
            end
         end
         default: begin
            // Sticky error or packet already ended: the byte is swallowed.
            active = 1'b0;
         end
      endcase

      // The last byte of a buffer inside an unfinished structure adds an error.
      tail_err = last && active &&
                 ((st_in.mode == ccnb_tok_pkg::MODE_PAYLOAD) ||
                  ((st_in.mode == ccnb_tok_pkg::MODE_HEADER) &&
                   (hcount_in != '0 || st_in.depth != '0)));
      if (tail_err) begin
         st_in.mode = ccnb_tok_pkg::MODE_ERROR;
      end

      err_tok.kind  = ccnb_tok_pkg::KIND_ERROR;
      err_tok.tol   = '0;
      err_tok.data  = '0;
      err_tok.depth = st_in.depth;
      err_tok.last  = 1'b1;

      if (emit) begin
         tok0.kind  = kind;
         tok0.tol   = tol;
         tok0.data  = dbyte;
         tok0.depth = st_in.depth;
         tok0.last  = !tail_err;
      end else begin
         tok0 = err_tok;
      end
      tok1 = err_tok;
      ntok = {1'b0, emit} + {1'b0, tail_err};
   end

endmodule

[rtl/ccnb_tok_outbuf.sv]
// Two-slot token buffer driving the result channel of the tokenizer.
// Loaded with all tokens of one byte at once and drained one per transfer.
// Depends on ccnb_tok_pkg.
module ccnb_tok_outbuf (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [1:0]                push_cnt,
   input  ccnb_tok_pkg::token_type   push_tok0,
   input  ccnb_tok_pkg::token_type   push_tok1,
   output logic                      can_push,
   output logic                      out_valid,
   input  logic                      out_ready,
   output ccnb_tok_pkg::token_type   out_tok
);

   ccnb_tok_pkg::token_type slot0_ff, slot0_in;
   ccnb_tok_pkg::token_type slot1_ff, slot1_in;
   logic [1:0]              cnt_ff, cnt_in;
   logic                    pop;

   assign pop       = (cnt_ff != 2'd0) && out_ready;
   // A new byte may enter once whatever is left will have gone by this edge.
   assign can_push  = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && out_ready);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_tok   = slot0_ff;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      cnt_in   = cnt_ff;
      if (push) begin
         slot0_in = push_tok0;
         slot1_in = push_tok1;
         cnt_in   = push_cnt;
      end else if (pop) begin
         slot0_in = slot1_ff;
         cnt_in   = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

`ifndef SYNTH
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("token buffer count out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      push |-> (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && pop)))
      else $error("token buffer loaded over an undelivered token");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      (push && push_cnt != 2'd0) |=> out_valid)
      else $error("pushed tokens not presented");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> !slot0_ff.last)
      else $error("first of two tokens marked as last of run");
`endif

endmodule

[rtl/ccnb_element_tokenizer_unit.sv]
// Top level of the CCNb element tokenizer: stream ports, configuration
// register, parser state registers. Depends on ccnb_tok_pkg,
// ccnb_tok_parse and ccnb_tok_outbuf.

// The tokenizer takes one byte of a CCNb binary XML packet per transfer on
// the req_ channel and gives the tokens that byte completes on the rsp_
// channel: opens, blob and text starts, payload bytes, closes, the packet
// end and errors. All the parsing for a byte is done in a single pass of
// combinational logic at the input, and the parser state is updated at the
// edge on which the byte is taken; the byte's tokens appear on the result
// channel from the next cycle on. After a byte that causes no token or one
// token, a byte can be accepted in every cycle while the result side keeps
// up. A byte that causes two tokens (its own token and an error for a
// buffer that ends inside an unfinished structure) holds off the next byte
// until the first of its tokens is taken from the two-slot token buffer.
// The token buffer also parts the two sides: a byte is accepted while the
// last token of the previous byte is being taken. Every token of a byte
// carries the nesting depth after it, and the final token of a byte has
// rsp_tlast set. After an error or the packet end, bytes are swallowed
// without tokens until a byte with start of packet set. The depth limit
// register sits at byte address 0 and should only be written while no
// byte is in flight. No clearing pass is needed after reset.
module ccnb_element_tokenizer_unit #(
   parameter int HDR_BYTES = ccnb_tok_pkg::HDR_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,

   // Input byte stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] start_of_packet
   input  logic        req_tlast,   // last_byte

   // Token stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [24:0] tag_or_length, [32:25] data_byte,
                                    // [37:33] nest_depth, [39:38] zero
   output logic [2:0]  rsp_tuser,   // [2:0] token_kind
   output logic        rsp_tlast,   // last_of_run

   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int HCW = (HDR_BYTES > 1) ? $clog2(HDR_BYTES) : 1;

   logic                                   accept;
   logic                                   cfg_write;

   logic [ccnb_tok_pkg::DEPTH_W-1:0]       depth_limit_ff, depth_limit_in;
   ccnb_tok_pkg::state_type                state_ff, state_in;
   logic [HCW-1:0]                         hcount_ff, hcount_in;

   ccnb_tok_pkg::token_type                tok0;
   ccnb_tok_pkg::token_type                tok1;
   logic [1:0]                             ntok;
   logic                                   can_push;
   ccnb_tok_pkg::token_type                head_tok;

   assign accept = req_tvalid && req_tready;

   // The register is written in the access phase; the word index is bit 2.
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == ccnb_tok_pkg::REG_DEPTH_LIMIT);

   always_comb begin
      depth_limit_in = depth_limit_ff;
      if (cfg_write) begin
         depth_limit_in = csr_pwdata[ccnb_tok_pkg::DEPTH_W-1:0];
      end
   end

   always_comb begin
      if (csr_paddr[2] == ccnb_tok_pkg::REG_DEPTH_LIMIT) begin
         csr_prdata = {{(32-ccnb_tok_pkg::DEPTH_W){1'b0}}, depth_limit_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_limit_ff <= ccnb_tok_pkg::DEPTH_LIMIT_RST;
      end else begin
         depth_limit_ff <= depth_limit_in;
      end
   end

   // Parse step for the byte on the input; its result is taken only on a
   // transfer.
   ccnb_tok_parse #(
      .HDR_BYTES (HDR_BYTES)
   ) u_parse (
      .in_byte     (req_tdata),
      .sop         (req_tuser),
      .last        (req_tlast),
      .st          (state_ff),
      .hcount      (hcount_ff),
      .depth_limit (depth_limit_ff),
      .st_in       (state_in),
      .hcount_in   (hcount_in),
      .tok0        (tok0),
      .tok1        (tok1),
      .ntok        (ntok)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode  <= ccnb_tok_pkg::MODE_HEADER;
         state_ff.accum <= '0;
         state_ff.left  <= '0;
         state_ff.depth <= '0;
         hcount_ff      <= '0;
      end else if (accept) begin
         state_ff  <= state_in;
         hcount_ff <= hcount_in;
      end
   end

   ccnb_tok_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_cnt  (ntok),
      .push_tok0 (tok0),
      .push_tok1 (tok1),
      .can_push  (can_push),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_tok   (head_tok)
   );

   assign req_tready = can_push;

   assign rsp_tdata = {2'b00, head_tok.depth, head_tok.data, head_tok.tol};
   assign rsp_tuser = head_tok.kind;
   assign rsp_tlast = head_tok.last;

endmodule

[tb/tb_ccnb_element_tokenizer_unit.sv]
`timescale 1ns / 100ps
// Self-checking testbench for ccnb_element_tokenizer_unit: packet bytes in,
// tokens out, each token compared with a behavioural prediction.
// Depends on ccnb_tok_pkg and the tokenizer RTL only.

import ccnb_tok_pkg::*;

// Keeps a shadow copy of the parser state, predicts the tokens each accepted
// byte should give and compares every token transfer with the oldest one due.
class token_tracker;
   token_type          tokens_due[$];
   token_type          fresh[$];
   int                 errors;
   int                 bytes_parsed;
   int                 tokens_seen;
   logic [DEPTH_W-1:0] depth_limit;
   mode_type           mode;
   logic [TOL_W-1:0]   accum;
   logic [TOL_W-1:0]   left;
   logic [DEPTH_W-1:0] depth;
   int                 hdr_count;

   function new();
      errors = 0;
      bytes_parsed = 0;
      tokens_seen = 0;
      depth_limit = DEPTH_LIMIT_RST;
      clear_parser();
   endfunction

   function void clear_parser();
      mode = MODE_HEADER;
      accum = '0;
      left = '0;
      depth = '0;
      hdr_count = 0;
   endfunction

   function int eff_limit();
      return (int'(depth_limit) < MAX_DEPTH) ? int'(depth_limit) : MAX_DEPTH;
   endfunction

   function void add(kind_type kind, logic [TOL_W-1:0] tol, logic [DATA_W-1:0] data);
      token_type t;
      t.kind = kind;
      t.tol = tol;
      t.data = data;
      t.depth = depth;
      t.last = 1'b0;
      fresh.push_back(t);
   endfunction

   function void header_byte(logic [7:0] b);
      logic [TOL_W-1:0] num;
      if (hdr_count == 0 && b == 8'h00) begin
         if (depth == 0) begin
            mode = MODE_DONE;
            add(KIND_END, '0, '0);
         end else begin
            depth = depth - 1'b1;
            add(KIND_CLOSE, '0, '0);
         end
      end else if (!b[7]) begin
         accum = {accum[TOL_W-8:0], b[6:0]};
         hdr_count++;
         if (hdr_count >= HDR_BYTES_DEF) begin
            mode = MODE_ERROR;
            add(KIND_ERROR, '0, '0);
         end
      end else begin
         num = {accum[TOL_W-5:0], b[6:3]};
         accum = '0;
         hdr_count = 0;
         case (b[2:0])
            HT_DTAG, HT_DATTR: begin
               if (int'(depth) + 1 > eff_limit()) begin
                  mode = MODE_ERROR;
                  add(KIND_ERROR, '0, '0);
               end else begin
                  depth = depth + 1'b1;
                  add((b[2:0] == HT_DTAG) ? KIND_OPEN_TAG : KIND_OPEN_ATTR, num, '0);
               end
            end
            HT_BLOB, HT_UDATA: begin
               add((b[2:0] == HT_BLOB) ? KIND_BLOB : KIND_TEXT, num, '0);
               if (num != 0) begin
                  left = num;
                  mode = MODE_PAYLOAD;
               end
            end
            default: begin
               mode = MODE_ERROR;
               add(KIND_ERROR, '0, '0);
            end
         endcase
      end
   endfunction

   // Works out the tokens that one accepted byte gives and queues them.
   function void predict_tokens(logic [7:0] b, logic sop, logic last);
      fresh.delete();
      if (sop)
         clear_parser();
      if (mode == MODE_ERROR || mode == MODE_DONE)
         return;
      bytes_parsed++;
      if (mode == MODE_HEADER) begin
         header_byte(b);
      end else begin
         add(KIND_PAYLOAD, '0, b);
         left = left - 1'b1;
         if (left == 0)
            mode = MODE_HEADER;
      end
      if (last && (mode == MODE_HEADER || mode == MODE_PAYLOAD) &&
          (mode == MODE_PAYLOAD || hdr_count != 0 || depth != 0)) begin
         mode = MODE_ERROR;
         add(KIND_ERROR, '0, '0);
      end
      if (fresh.size() > 0)
         fresh[fresh.size()-1].last = 1'b1;
      foreach (fresh[i])
         tokens_due.push_back(fresh[i]);
   endfunction

   task report(string msg);
      $display("%0t MISMATCH: %s", $time, msg);
      errors++;
   endtask

   task check_token(logic [2:0] kind, logic [TOL_W-1:0] tol, logic [DATA_W-1:0] data,
                    logic [DEPTH_W-1:0] dep, logic last, logic [1:0] pad);
      token_type want;
      tokens_seen++;
      if (tokens_due.size() == 0) begin
         report($sformatf("token %0d kind %0d arrived with none due", tokens_seen, kind));
         return;
      end
      want = tokens_due.pop_front();
      if (kind !== want.kind)
         report($sformatf("token %0d kind %0d, want %s", tokens_seen, kind,
                          want.kind.name()));
      if (tol !== want.tol)
         report($sformatf("token %0d tag_or_length %0h, want %0h", tokens_seen, tol,
                          want.tol));
      if (data !== want.data)
         report($sformatf("token %0d data_byte %0h, want %0h", tokens_seen, data,
                          want.data));
      if (dep !== want.depth)
         report($sformatf("token %0d nest_depth %0d, want %0d", tokens_seen, dep,
                          want.depth));
      if (last !== want.last)
         report($sformatf("token %0d last_of_run %b, want %b", tokens_seen, last,
                          want.last));
      if (pad !== 2'b00)
         report($sformatf("token %0d padding bits %b not zero", tokens_seen, pad));
   endtask
endclass

module tb_ccnb_element_tokenizer_unit;

   // Header type codes that the tokenizer must reject.
   localparam logic [2:0] HT_EXT  = 3'd0;
   localparam logic [2:0] HT_TAG  = 3'd1;
   localparam logic [2:0] HT_ATTR = 3'd3;
   localparam logic [2:0] HT_BAD  = 3'd7;

   localparam logic [2:0] LIMIT_ADDR = 3'(4 * int'(REG_DEPTH_LIMIT));

   // A token appears the cycle after its byte, so a few quiet cycles are
   // ample for the block to settle before the depth limit is rewritten.
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES   = 60;
   localparam int PHASE_BYTES   = 130;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] in_byte
   logic        req_tuser;    // [0] start_of_packet
   logic        req_tlast;    // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;    // [24:0] tag_or_length, [32:25] data_byte,
                              // [37:33] nest_depth, [39:38] zero
   logic [2:0]  rsp_tuser;    // [2:0] token_kind
   logic        rsp_tlast;    // last_of_run
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   token_tracker sb;

   // Shared between the byte source and the token sink. calm switches off
   // all random idling for the closing stretch of the run; hold_req asks the
   // sink for one long hold-off while the source keeps offering bytes.
   logic       calm = 1'b0;
   logic       hold_req = 1'b0;
   int         src_idle_pct = 0;
   logic [7:0] packet_bytes[$];

   ccnb_element_tokenizer_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Both channels are observed at the rising edge. Tokens already in
   // flight are checked before the byte of this edge is predicted; since
   // the new byte's tokens join the back of the queue the order is immaterial.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_token(rsp_tuser, rsp_tdata[24:0], rsp_tdata[32:25], rsp_tdata[37:33],
                           rsp_tlast, rsp_tdata[39:38]);
         if (req_tvalid && req_tready)
            sb.predict_tokens(req_tdata, req_tuser, req_tlast);
      end
   end

   function automatic int pick_idle();
      case ($urandom_range(0, 3))
         0, 1: return 0;
         2: return 15;
         default: return 40;
      endcase
   endfunction

   // The token sink. Its readiness is decided at each falling edge: random
   // short idle bursts, windows with no idling at all, and the single long
   // hold-off, counted out here in cycles, that fills the block's token
   // buffer and forces it to stall the byte stream.
   initial begin : token_sink
      int window;
      int pct;
      window = 0;
      pct = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (window == 0) begin
            window = 40;
            pct = pick_idle();
         end
         window--;
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_tready <= 1'b1;
         end else if (!calm && $urandom_range(0, 99) < pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offers one byte and returns at the falling edge after its transfer.
   // It is entered at a falling edge, so tvalid is either held high into the
   // next byte or dropped for an idle burst, never both in one step.
   task automatic put_byte(logic [7:0] b, logic sop, logic last);
      if (!calm && $urandom_range(0, 99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= sop;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Stops the byte stream, waits for every outstanding token and then lets
   // the block settle for a few cycles.
   task automatic drain_tokens();
      req_tvalid <= 1'b0;
      while (sb.tokens_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes the depth limit with a setup and an access cycle, then reads it
   // back the same way.
   task automatic write_depth_limit(logic [DEPTH_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= LIMIT_ADDR;
      csr_pwdata <= 32'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      sb.depth_limit = value;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      if (csr_prdata !== 32'(value))
         sb.report($sformatf("depth limit reads back %0h, want %0h", csr_prdata, value));
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [2:0] pick_open();
      return $urandom_range(0, 1) ? HT_DTAG : HT_DATTR;
   endfunction

   function automatic logic [2:0] pick_data_type();
      return $urandom_range(0, 1) ? HT_BLOB : HT_UDATA;
   endfunction

   function automatic logic [2:0] pick_bad_type();
      case ($urandom_range(0, 3))
         0: return HT_EXT;
         1: return HT_TAG;
         2: return HT_ATTR;
         default: return HT_BAD;
      endcase
   endfunction

   // A header of nprefix seven-bit bytes, the first one non-zero so that it
   // cannot read as a close, followed by the closing byte.
   function automatic void add_header(int nprefix, logic [3:0] nib, logic [2:0] htype);
      for (int i = 0; i < nprefix; i++)
         packet_bytes.push_back(i == 0 ? 8'($urandom_range(1, 127)) : 8'($urandom_range(0, 127)));
      packet_bytes.push_back({1'b1, nib, htype});
   endfunction

   // A blob or text header announcing len bytes, followed by that payload.
   function automatic void add_data(int len, logic [2:0] htype);
      if (len >= 16)
         packet_bytes.push_back(8'(len >> 4));
      packet_bytes.push_back({1'b1, 4'(len), htype});
      repeat (len) packet_bytes.push_back(8'($urandom));
   endfunction

   function automatic int pick_length();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return $urandom_range(16, 40);
         default: return $urandom_range(1, 12);
      endcase
   endfunction

   // Something the tokenizer must flag: an unknown type, an over-long
   // header, or a huge announced length that the buffer never delivers.
   // Whatever follows the fault is swallowed until the next packet.
   function automatic void add_fault();
      case ($urandom_range(0, 2))
         0: add_header($urandom_range(0, 3), 4'($urandom), pick_bad_type());
         1: add_header(HDR_BYTES_DEF, 4'($urandom), HT_DTAG);
         default: begin
            add_header(3, 4'($urandom), pick_data_type());
            repeat ($urandom_range(0, 4)) packet_bytes.push_back(8'($urandom));
         end
      endcase
      repeat ($urandom_range(0, 3)) packet_bytes.push_back(8'($urandom));
   endfunction

   // Builds one packet: mostly a well-formed element tree with random tags,
   // blobs and text, now and then a nest that runs to the depth limit or one
   // beyond it, and sometimes a fault part-way through.
   function automatic void build_packet(int lim);
      int depth_now;
      int pick;
      depth_now = 0;
      packet_bytes.delete();
      if ($urandom_range(0, 9) == 0) begin
         repeat (lim + $urandom_range(0, 1))
            add_header($urandom_range(0, 1), 4'($urandom), pick_open());
         repeat (lim + 1) packet_bytes.push_back(8'h00);
         return;
      end
      repeat ($urandom_range(1, 16)) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            add_fault();
            return;
         end else if (pick < 9 && depth_now < lim) begin
            add_header($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0, 4'($urandom),
                       pick_open());
            depth_now++;
         end else if (pick < 14 || depth_now == 0) begin
            add_data(pick_length(), pick_data_type());
         end else begin
            packet_bytes.push_back(8'h00);
            depth_now--;
         end
      end
      repeat (depth_now + 1) packet_bytes.push_back(8'h00);
      // Stray bytes after the packet end must be swallowed.
      if ($urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 2)) packet_bytes.push_back(8'($urandom));
   endfunction

   // Sends one packet with start of packet on its first byte. Most carry the
   // last-byte flag on their final byte; some are cut short with the flag on
   // an earlier byte, and some carry no flag and are cleared by the next start.
   task automatic send_packet();
      int cut;
      int ending;
      src_idle_pct = pick_idle();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 6))
            put_byte(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
         return;
      end
      build_packet(sb.eff_limit());
      cut = packet_bytes.size() - 1;
      ending = $urandom_range(0, 9);
      if (ending == 0)
         cut = $urandom_range(0, cut);
      for (int i = 0; i <= cut; i++)
         put_byte(packet_bytes[i], i == 0, i == cut && ending != 1);
   endtask

   // Hand-picked bytes at the reset depth limit: end and close handling,
   // the widest tag, a zero byte as header value, an over-long header,
   // empty and short payloads, every rejected type, and buffers that end
   // inside an element or inside a header.
   task automatic directed_bytes();
      put_byte(8'h00, 1'b1, 1'b0);
      put_byte(8'h55, 1'b0, 1'b0);
      put_byte(8'h7F, 1'b1, 1'b0);
      put_byte(8'h7F, 1'b0, 1'b0);
      put_byte(8'h7F, 1'b0, 1'b0);
      put_byte({1'b1, 4'hF, HT_DTAG}, 1'b0, 1'b0);
      put_byte(8'h01, 1'b0, 1'b0);
      put_byte(8'h00, 1'b0, 1'b0);
      put_byte({1'b1, 4'h3, HT_DATTR}, 1'b0, 1'b0);
      repeat (HDR_BYTES_DEF) put_byte(8'h01, 1'b0, 1'b0);
      put_byte({1'b1, 4'h0, HT_DTAG}, 1'b1, 1'b0);
      put_byte({1'b1, 4'h0, HT_BLOB}, 1'b0, 1'b0);
      put_byte({1'b1, 4'h2, HT_UDATA}, 1'b0, 1'b0);
      put_byte(8'h00, 1'b0, 1'b0);
      put_byte(8'hFF, 1'b0, 1'b0);
      put_byte(8'h00, 1'b0, 1'b0);
      put_byte(8'h00, 1'b0, 1'b1);
      put_byte({1'b1, 4'hF, HT_EXT}, 1'b1, 1'b1);
      put_byte({1'b1, 4'h0, HT_TAG}, 1'b1, 1'b0);
      put_byte({1'b1, 4'h0, HT_ATTR}, 1'b1, 1'b0);
      put_byte({1'b1, 4'h0, HT_BAD}, 1'b1, 1'b0);
      put_byte({1'b1, 4'h0, HT_DTAG}, 1'b1, 1'b1);
      put_byte(8'h01, 1'b1, 1'b1);
   endtask

   // Main sequence: reset, the directed bytes, then random phases, each at
   // its own depth limit written while the block is idle. The limits include
   // both extremes; the third phase carries the long hold-off at the sink and
   // the final phase runs with no idling on either side.
   initial begin : stimulus
      int target;
      logic [DEPTH_W-1:0] limit;
      logic hold_sent;
      sb = new();
      hold_sent = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      req_tlast = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      directed_bytes();
      for (int phase = 0; phase < 6; phase++) begin
         drain_tokens();
         case (phase)
            0: limit = 5'd1;
            1: limit = 5'd16;
            3: limit = 5'd2;
            5: limit = 5'd16;
            default: limit = 5'($urandom_range(1, 16));
         endcase
         write_depth_limit(limit);
         if (phase == 5)
            calm = 1'b1;
         target = sb.bytes_parsed + PHASE_BYTES;
         while (sb.bytes_parsed < target) begin
            // Packets end on uneven byte counts, so the hold-off is asked for
            // once the phase has passed its thirtieth byte.
            if (phase == 2 && !hold_sent &&
                sb.bytes_parsed >= target - PHASE_BYTES + 30) begin
               hold_req = 1'b1;
               hold_sent = 1'b1;
            end
            send_packet();
         end
      end
      drain_tokens();
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // The slowest correct run is well under a millisecond of simulated time.
   initial begin : watchdog
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

[sim.f]
rtl/ccnb_tok_pkg.sv
rtl/ccnb_tok_parse.sv
rtl/ccnb_tok_outbuf.sv
rtl/ccnb_element_tokenizer_unit.sv
tb/tb_ccnb_element_tokenizer_unit.sv
